// ===== src/linear_solve_3x3_cramer_defines.svh =====
// assertion macros used by the checker file
`ifndef LINEAR_SOLVE_3X3_CRAMER_DEFINES_SVH
`define LINEAR_SOLVE_3X3_CRAMER_DEFINES_SVH

// checked outside reset only
`define LS3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LS3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ls3_pkg.sv =====
package ls3_pkg;

  localparam int DW     = 32;
  localparam int FRAC   = 16;
  localparam int TW     = 2 * DW + 1;
  localparam int PPW    = 2 * DW + 1;
  localparam int NUM_W  = 3 * DW + 3;
  // cofactor 2 + dot 3 + divide lane DW+3
  localparam int LAT    = DW + 8;

  typedef logic signed [DW-1:0]    word_t;
  typedef logic signed [2*DW-1:0]  prod_t;
  typedef logic signed [TW-1:0]    cof_t;
  typedef logic signed [PPW-1:0]   pp_t;
  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic        [NUM_W-1:0] mag_t;

  typedef struct packed {
    word_t a, b, c, d, e, f, g, h, i, j, k, l;
  } mat_t;

  typedef struct packed {
    cof_t t1, t2, t3, u1, u2, u3;
  } cof_set_t;

  typedef struct packed {
    logic qb;
    mag_t rem;
  } step_t;

  // one restoring division step
  function automatic step_t div_step(mag_t rem, mag_t den, logic nbit);
    logic [NUM_W:0] sh;
    logic [NUM_W:0] dd;
    step_t          r;
    sh = {rem, nbit};
    dd = {1'b0, den};
    if (sh >= dd) begin
      r.qb  = 1'b1;
      r.rem = mag_t'(sh - dd);
    end else begin
      r.qb  = 1'b0;
      r.rem = mag_t'(sh);
    end
    return r;
  endfunction

endpackage

// ===== src/ls3_cofactor.sv =====
module ls3_cofactor (
  input  logic              clk,
  input  logic              en,
  input  ls3_pkg::mat_t     m_in,
  output ls3_pkg::mat_t     m_out,
  output ls3_pkg::cof_set_t cof
);

  ls3_pkg::prod_t   p_r [12];
  ls3_pkg::mat_t    m1_r;
  ls3_pkg::mat_t    m2_r;
  ls3_pkg::cof_set_t cof_r;

  // stage 1: the twelve 2x2 products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]  <= ls3_pkg::prod_t'(m_in.e) * ls3_pkg::prod_t'(m_in.i);
      p_r[1]  <= ls3_pkg::prod_t'(m_in.h) * ls3_pkg::prod_t'(m_in.f);
      p_r[2]  <= ls3_pkg::prod_t'(m_in.g) * ls3_pkg::prod_t'(m_in.f);
      p_r[3]  <= ls3_pkg::prod_t'(m_in.d) * ls3_pkg::prod_t'(m_in.i);
      p_r[4]  <= ls3_pkg::prod_t'(m_in.d) * ls3_pkg::prod_t'(m_in.h);
      p_r[5]  <= ls3_pkg::prod_t'(m_in.e) * ls3_pkg::prod_t'(m_in.g);
      p_r[6]  <= ls3_pkg::prod_t'(m_in.a) * ls3_pkg::prod_t'(m_in.k);
      p_r[7]  <= ls3_pkg::prod_t'(m_in.j) * ls3_pkg::prod_t'(m_in.b);
      p_r[8]  <= ls3_pkg::prod_t'(m_in.j) * ls3_pkg::prod_t'(m_in.c);
      p_r[9]  <= ls3_pkg::prod_t'(m_in.a) * ls3_pkg::prod_t'(m_in.l);
      p_r[10] <= ls3_pkg::prod_t'(m_in.b) * ls3_pkg::prod_t'(m_in.l);
      p_r[11] <= ls3_pkg::prod_t'(m_in.k) * ls3_pkg::prod_t'(m_in.c);
      m1_r    <= m_in;
    end
  end

  // stage 2: differences
  always_ff @(posedge clk) begin
    if (en) begin
      cof_r.t1 <= ls3_pkg::cof_t'(p_r[0])  - ls3_pkg::cof_t'(p_r[1]);
      cof_r.t2 <= ls3_pkg::cof_t'(p_r[2])  - ls3_pkg::cof_t'(p_r[3]);
      cof_r.t3 <= ls3_pkg::cof_t'(p_r[4])  - ls3_pkg::cof_t'(p_r[5]);
      cof_r.u1 <= ls3_pkg::cof_t'(p_r[6])  - ls3_pkg::cof_t'(p_r[7]);
      cof_r.u2 <= ls3_pkg::cof_t'(p_r[8])  - ls3_pkg::cof_t'(p_r[9]);
      cof_r.u3 <= ls3_pkg::cof_t'(p_r[10]) - ls3_pkg::cof_t'(p_r[11]);
      m2_r     <= m1_r;
    end
  end

  assign m_out = m2_r;
  assign cof   = cof_r;

endmodule

// ===== src/ls3_dot.sv =====
module ls3_dot (
  input  logic                 clk,
  input  logic                 en,
  input  ls3_pkg::word_t       a,
  input  ls3_pkg::word_t       b,
  input  ls3_pkg::word_t       c,
  input  ls3_pkg::cof_t        ta,
  input  ls3_pkg::cof_t        tb,
  input  ls3_pkg::cof_t        tc,
  output ls3_pkg::num_t        sum
);

  ls3_pkg::word_t w [3];
  ls3_pkg::cof_t  t [3];
  ls3_pkg::pp_t   lo_r [3];
  ls3_pkg::pp_t   hi_r [3];
  ls3_pkg::num_t  prod_r [3];
  ls3_pkg::num_t  sum_r;

  assign w[0] = a;
  assign w[1] = b;
  assign w[2] = c;
  assign t[0] = ta;
  assign t[1] = tb;
  assign t[2] = tc;

  // split the wide cofactor: unsigned low word, signed high part
  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        lo_r[n] <= ls3_pkg::pp_t'(w[n])
                   * ls3_pkg::pp_t'($signed({1'b0, t[n][ls3_pkg::DW-1:0]}));
        hi_r[n] <= ls3_pkg::pp_t'(w[n])
                   * ls3_pkg::pp_t'($signed(t[n][ls3_pkg::TW-1:ls3_pkg::DW]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 3; n++) begin
        prod_r[n] <= (ls3_pkg::num_t'(hi_r[n]) <<< ls3_pkg::DW)
                     + ls3_pkg::num_t'(lo_r[n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= prod_r[0] + prod_r[1] + prod_r[2];
    end
  end

  assign sum = sum_r;

endmodule

// ===== src/ls3_div_lane.sv =====
module ls3_div_lane (
  input  logic           clk,
  input  logic           en,
  input  ls3_pkg::num_t  num,
  input  ls3_pkg::num_t  den,
  input  logic           flip,
  output ls3_pkg::word_t q,
  output logic           sat,
  output logic           den_zero
);

  localparam int DW = ls3_pkg::DW;
  localparam int FR = ls3_pkg::FRAC;

  ls3_pkg::mag_t  nmag_r;
  ls3_pkg::mag_t  dmag_r;
  logic           neg1_r;
  logic           zero1_r;

  ls3_pkg::mag_t  rem_r  [DW+1];
  ls3_pkg::mag_t  den_r  [DW+1];
  logic [DW-1:0]  q_r    [DW+1];
  logic [DW-1:0]  nb_r   [DW+1];
  logic           neg_r  [DW+1];
  logic           ovf_r  [DW+1];
  logic           zero_r [DW+1];

  ls3_pkg::word_t q_out_r;
  logic           sat_out_r;
  logic           zero_out_r;

  // magnitudes and sign
  always_ff @(posedge clk) begin
    if (en) begin
      nmag_r  <= num[ls3_pkg::NUM_W-1] ? ls3_pkg::mag_t'(-num) : ls3_pkg::mag_t'(num);
      dmag_r  <= den[ls3_pkg::NUM_W-1] ? ls3_pkg::mag_t'(-den) : ls3_pkg::mag_t'(den);
      neg1_r  <= num[ls3_pkg::NUM_W-1] ^ den[ls3_pkg::NUM_W-1] ^ flip;
      zero1_r <= (den == '0);
    end
  end

  // quotient wider than DW bits means overflow
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0]  <= {{FR{1'b0}}, nmag_r} >= {dmag_r, {FR{1'b0}}};
      rem_r[0]  <= ls3_pkg::mag_t'(nmag_r >> (DW - FR));
      nb_r[0]   <= {nmag_r[DW-FR-1:0], {FR{1'b0}}};
      q_r[0]    <= '0;
      den_r[0]  <= dmag_r;
      neg_r[0]  <= neg1_r;
      zero_r[0] <= zero1_r;
    end
  end

  for (genvar s = 0; s < DW; s++) begin : g_step
    ls3_pkg::step_t st;
    assign st = ls3_pkg::div_step(rem_r[s], den_r[s], nb_r[s][DW-1]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= st.rem;
        q_r[s+1]    <= {q_r[s][DW-2:0], st.qb};
        nb_r[s+1]   <= {nb_r[s][DW-2:0], 1'b0};
        den_r[s+1]  <= den_r[s];
        neg_r[s+1]  <= neg_r[s];
        ovf_r[s+1]  <= ovf_r[s];
        zero_r[s+1] <= zero_r[s];
      end
    end
  end

  // clamp, sign and singular masking
  logic           clamp;
  logic [DW-1:0]  qf;
  assign qf    = q_r[DW];
  assign clamp = ovf_r[DW] | (neg_r[DW] ? (qf[DW-1] & (|qf[DW-2:0])) : qf[DW-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      zero_out_r <= zero_r[DW];
      if (zero_r[DW]) begin
        q_out_r   <= '0;
        sat_out_r <= 1'b0;
      end else if (clamp) begin
        q_out_r   <= neg_r[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        sat_out_r <= 1'b1;
      end else begin
        q_out_r   <= neg_r[DW] ? ls3_pkg::word_t'(-qf) : ls3_pkg::word_t'(qf);
        sat_out_r <= 1'b0;
      end
    end
  end

  assign q        = q_out_r;
  assign sat      = sat_out_r;
  assign den_zero = zero_out_r;

endmodule

// ===== src/linear_solve_3x3_cramer.sv =====
// channel  | handshake               | payload
// in_      | in_valid / in_ready     | row1_col1 .. row3_col3, rhs_x .. rhs_z (Q16.16)
// out_     | out_valid / out_ready   | sol_x, sol_y, sol_z (Q16.16), singular, saturated
//
// one request per cycle while the output register is free or being taken; the
// restoring divider lanes produce one quotient bit per stage
// rst_n is synchronous and clears only the valid chain
// a stall on out_ready freezes the whole pipeline; nothing is lost or repeated
module linear_solve_3x3_cramer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    in_row1_col1,
  input  logic signed [31:0]    in_row1_col2,
  input  logic signed [31:0]    in_row1_col3,
  input  logic signed [31:0]    in_row2_col1,
  input  logic signed [31:0]    in_row2_col2,
  input  logic signed [31:0]    in_row2_col3,
  input  logic signed [31:0]    in_row3_col1,
  input  logic signed [31:0]    in_row3_col2,
  input  logic signed [31:0]    in_row3_col3,
  input  logic signed [31:0]    in_rhs_x,
  input  logic signed [31:0]    in_rhs_y,
  input  logic signed [31:0]    in_rhs_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_sol_x,
  output logic signed [31:0]    out_sol_y,
  output logic signed [31:0]    out_sol_z,
  output logic                  out_singular,
  output logic                  out_saturated
);

  localparam int LAT = ls3_pkg::LAT;

  logic              en;
  logic [LAT-1:0]    vld_r;
  ls3_pkg::mat_t     m_in;
  ls3_pkg::mat_t     m2;
  ls3_pkg::cof_set_t cof;
  ls3_pkg::num_t     det, nx, ny, nz;
  logic              sat_x, sat_y, sat_z;
  logic              det_zero;

  // the pipeline moves whenever the output register is free or being taken
  assign en       = out_ready | ~vld_r[LAT-1];
  assign in_ready = en;

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // letter names run column-major: a, b, c are column 1, j, k, l the right-hand side
  assign m_in.a = in_row1_col1;
  assign m_in.d = in_row1_col2;
  assign m_in.g = in_row1_col3;
  assign m_in.b = in_row2_col1;
  assign m_in.e = in_row2_col2;
  assign m_in.h = in_row2_col3;
  assign m_in.c = in_row3_col1;
  assign m_in.f = in_row3_col2;
  assign m_in.i = in_row3_col3;
  assign m_in.j = in_rhs_x;
  assign m_in.k = in_rhs_y;
  assign m_in.l = in_rhs_z;

  ls3_cofactor u_cof (
    .clk   (clk),
    .en    (en),
    .m_in  (m_in),
    .m_out (m2),
    .cof   (cof)
  );

  // determinant and the three numerators, exact
  ls3_dot u_det (
    .clk (clk), .en (en),
    .a (m2.a), .b (m2.b), .c (m2.c),
    .ta (cof.t1), .tb (cof.t2), .tc (cof.t3),
    .sum (det)
  );

  ls3_dot u_nx (
    .clk (clk), .en (en),
    .a (m2.j), .b (m2.k), .c (m2.l),
    .ta (cof.t1), .tb (cof.t2), .tc (cof.t3),
    .sum (nx)
  );

  ls3_dot u_ny (
    .clk (clk), .en (en),
    .a (m2.i), .b (m2.h), .c (m2.g),
    .ta (cof.u1), .tb (cof.u2), .tc (cof.u3),
    .sum (ny)
  );

  // z numerator is the negated sum: handled by flipping the quotient sign
  ls3_dot u_nz (
    .clk (clk), .en (en),
    .a (m2.f), .b (m2.e), .c (m2.d),
    .ta (cof.u1), .tb (cof.u2), .tc (cof.u3),
    .sum (nz)
  );

  ls3_div_lane u_div_x (
    .clk (clk), .en (en), .num (nx), .den (det), .flip (1'b0),
    .q (out_sol_x), .sat (sat_x), .den_zero (det_zero)
  );

  ls3_div_lane u_div_y (
    .clk (clk), .en (en), .num (ny), .den (det), .flip (1'b0),
    .q (out_sol_y), .sat (sat_y), .den_zero ()
  );

  ls3_div_lane u_div_z (
    .clk (clk), .en (en), .num (nz), .den (det), .flip (1'b1),
    .q (out_sol_z), .sat (sat_z), .den_zero ()
  );

  assign out_valid     = vld_r[LAT-1];
  assign out_singular  = det_zero;
  assign out_saturated = sat_x | sat_y | sat_z;

endmodule

// ===== src/ls3_checker.sv =====
`include "linear_solve_3x3_cramer_defines.svh"

module ls3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_sol_x,
  input logic signed [31:0] out_sol_y,
  input logic signed [31:0] out_sol_z,
  input logic               out_singular,
  input logic               out_saturated
);

  // singular results carry zeros and no clamp
  `LS3_ASSERT(a_singular_zero, (out_valid && out_singular) |-> (out_sol_x == 0 && out_sol_y == 0 && out_sol_z == 0 && !out_saturated), "singular result not zeroed")

  // a taker downstream never blocks the input side
  `LS3_ASSERT(a_ready_follows, out_ready |-> in_ready, "input stalled while output is taken")

  // a held result stays put
  `LS3_ASSERT(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_sol_x) && $stable(out_saturated)), "stalled result changed")

  // nothing comes out straight after reset
  `LS3_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind linear_solve_3x3_cramer ls3_checker u_ls3_checker (.*);
